// ===== hw/rtl/qsort_pkg.sv =====
// ----------------------------------------------------------------------------
// qsort_pkg
// Shared sizes, types and the controller/datapath command and status bundles
// for the quicksort engine.
// ----------------------------------------------------------------------------
package qsort_pkg;

    // sizes
    localparam int MAX_ELEMENTS = 64;
    localparam int VALUE_BITS   = 16;
    localparam int STACK_DEPTH  = 64;
    localparam int COUNT_BITS   = 16;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int POS_W        = IDX_W + 2;
    localparam int SP_W         = $clog2(STACK_DEPTH) + 1;

    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef logic [IDX_W-1:0]             idx_t;
    typedef logic [CNT_W-1:0]             cnt_t;
    typedef logic signed [POS_W-1:0]      pos_t;
    typedef logic [SP_W-1:0]              sp_t;
    typedef logic [COUNT_BITS-1:0]        stat_t;
    typedef logic [2*IDX_W-1:0]           range_t;

    // store read address select
    typedef enum logic [2:0] {
        RD_MID    = 3'd0,
        RD_I      = 3'd1,
        RD_I_NEXT = 3'd2,
        RD_J      = 3'd3,
        RD_J_PREV = 3'd4,
        RD_K      = 3'd5
    } rd_sel_t;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    init_push;
        logic    pop;
        logic    range_load;
        logic    pivot_load;
        logic    i_step;
        logic    i_done;
        logic    j_step;
        logic    j_done;
        logic    swap_a;
        logic    swap_b;
        logic    cross_step;
        logic    push_hi;
        logic    push_lo;
        logic    out_start;
        logic    out_next;
        logic    run_clear;
        rd_sel_t rd_sel;
    } qsort_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sp_empty;
        logic range_bad;
        logic i_go;
        logic j_go;
        logic i_lt_j;
        logic i_le_j;
        logic gap_two;
        logic hi_pending;
        logic lo_pending;
        logic last_out;
    } qsort_stat_t;

endpackage

// ===== hw/rtl/quicksort_engine_with_counters_top.sv =====
// ----------------------------------------------------------------------------
// quicksort_engine_with_counters_top
// Loads signed values, sorts them with Hoare-partition quicksort and reads
// them out in ascending order with comparison and exchange counts.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, load_value, final_item): one item per
//   cycle is accepted while loading; each value is appended to a 64-entry
//   store, values beyond that are dropped and flagged. An item with
//   final_item set ends the run and starts the sort; no input is taken
//   again until the whole run has been read out.
//   Sort: a controller walks the partition passes one store access per cycle.
//   Output channel (out_valid/out_ready, sorted_value, run_end,
//   compare_count, swap_count, overflow_flag): one item per stored value,
//   each read from the store before it is offered, run_end on the last one. A stalled receiver
//   holds the current item unchanged; the block simply waits.
//   Reset: the store is empty, counters and flags are zero and the block
//   waits for input. Counters clear after the last item of a run is taken.
// ----------------------------------------------------------------------------
module quicksort_engine_with_counters_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] load_value,
    input  logic               final_item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] sorted_value,
    output logic               run_end,
    output logic [15:0]        compare_count,
    output logic [15:0]        swap_count,
    output logic               overflow_flag
);
    import qsort_pkg::*;

    qsort_cmd_t  cmd;
    qsort_stat_t stat;

    // sequencer
    qsort_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .final_item (final_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // store, stack and counters
    qsort_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .load_value    (load_value),
        .sorted_value  (sorted_value),
        .run_end       (run_end),
        .compare_count (compare_count),
        .swap_count    (swap_count),
        .overflow_flag (overflow_flag)
    );

endmodule

// ===== hw/rtl/qsort_dp.sv =====
// ----------------------------------------------------------------------------
// qsort_dp
// Datapath: value store, range stack, scan indices, pivot, counters and the
// readout index. Driven cycle by cycle by the controller.
// ----------------------------------------------------------------------------
module qsort_dp
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  qsort_pkg::qsort_cmd_t  cmd,
    output qsort_pkg::qsort_stat_t stat,
    input  logic signed [15:0]   load_value,
    output logic signed [15:0]   sorted_value,
    output logic                 run_end,
    output logic [15:0]          compare_count,
    output logic [15:0]          swap_count,
    output logic                 overflow_flag
);
    import qsort_pkg::*;

    value_t store_mem [MAX_ELEMENTS];
    range_t stack_mem [STACK_DEPTH];

    value_t store_rd_reg;
    range_t stack_rd_reg;
    value_t x_reg;
    value_t vi_reg;
    value_t vj_reg;
    idx_t   lo_reg;
    idx_t   hi_reg;
    pos_t   i_reg, i_next;
    pos_t   j_reg, j_next;
    cnt_t   count_reg, count_next;
    sp_t    sp_reg, sp_next;
    stat_t  cmp_reg, cmp_next;
    stat_t  swp_reg, swp_next;
    logic   dropped_reg, dropped_next;
    idx_t   k_reg, k_next;

    logic   full;
    idx_t   stk_lo, stk_hi;
    logic [IDX_W:0] mid_sum;
    pos_t   lo_pos, hi_pos, gap;
    pos_t   i_inc, j_dec;
    idx_t   rd_addr;
    logic   st_we;
    idx_t   st_waddr;
    value_t st_wdata;
    logic   stk_we;
    range_t stk_wdata;
    idx_t   stk_raddr;
    logic   cmp_bump;
    cnt_t   last_k;

    assign full    = count_reg[CNT_W-1];
    assign stk_lo  = stack_rd_reg[2*IDX_W-1:IDX_W];
    assign stk_hi  = stack_rd_reg[IDX_W-1:0];
    assign mid_sum = {1'b0, stk_lo} + {1'b0, stk_hi};
    assign lo_pos  = pos_t'({2'b00, lo_reg});
    assign hi_pos  = pos_t'({2'b00, hi_reg});
    assign i_inc   = i_reg + pos_t'(1);
    assign j_dec   = j_reg - pos_t'(1);
    assign gap     = j_reg - i_reg;
    assign last_k  = count_reg - cnt_t'(1);

    // store read address
    always_comb
    begin
        case (cmd.rd_sel)
            RD_MID:    rd_addr = mid_sum[IDX_W:1];
            RD_I:      rd_addr = i_reg[IDX_W-1:0];
            RD_I_NEXT: rd_addr = i_inc[IDX_W-1:0];
            RD_J:      rd_addr = j_reg[IDX_W-1:0];
            RD_J_PREV: rd_addr = j_dec[IDX_W-1:0];
            RD_K:      rd_addr = k_reg;
            default:   rd_addr = k_reg;
        endcase
    end

    // store write port: loads and the two halves of an exchange
    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = count_reg[IDX_W-1:0];
        st_wdata = load_value;
        if (cmd.load && !full)
        begin
            st_we = 1'b1;
        end
        else if (cmd.swap_a)
        begin
            st_we    = 1'b1;
            st_waddr = i_reg[IDX_W-1:0];
            st_wdata = vj_reg;
        end
        else if (cmd.swap_b)
        begin
            st_we    = 1'b1;
            st_waddr = j_reg[IDX_W-1:0];
            st_wdata = vi_reg;
        end
    end

    // value store
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_waddr] <= st_wdata;
        end
        store_rd_reg <= store_mem[rd_addr];
    end

    // range stack write data and read address
    always_comb
    begin
        stk_we    = 1'b0;
        stk_wdata = {idx_t'(0), last_k[IDX_W-1:0]};
        if (cmd.init_push)
        begin
            stk_we = 1'b1;
        end
        else if (cmd.push_hi && !sp_reg[SP_W-1])
        begin
            stk_we    = 1'b1;
            stk_wdata = {i_reg[IDX_W-1:0], hi_reg};
        end
        else if (cmd.push_lo && !sp_reg[SP_W-1])
        begin
            stk_we    = 1'b1;
            stk_wdata = {lo_reg, j_reg[IDX_W-1:0]};
        end
        stk_raddr = sp_reg[SP_W-2:0] - idx_t'(1);
    end

    // range stack
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[sp_reg[SP_W-2:0]] <= stk_wdata;
        end
        stack_rd_reg <= stack_mem[stk_raddr];
    end

    // partition operands
    always_ff @(posedge clk)
    begin
        if (cmd.range_load)
        begin
            lo_reg <= stk_lo;
            hi_reg <= stk_hi;
        end
        if (cmd.pivot_load)
        begin
            x_reg <= store_rd_reg;
        end
        if (cmd.i_done)
        begin
            vi_reg <= store_rd_reg;
        end
        if (cmd.j_done)
        begin
            vj_reg <= store_rd_reg;
        end
    end

    // next-state of indices, counts and counters
    always_comb
    begin
        i_next       = i_reg;
        j_next       = j_reg;
        count_next   = count_reg;
        sp_next      = sp_reg;
        cmp_next     = cmp_reg;
        swp_next     = swp_reg;
        dropped_next = dropped_reg;
        k_next       = k_reg;
        cmp_bump     = cmd.i_done | cmd.j_done | cmd.swap_b;

        if (cmd.load)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + cnt_t'(1);
            end
        end
        if (cmd.range_load)
        begin
            i_next = pos_t'({2'b00, stk_lo});
            j_next = pos_t'({2'b00, stk_hi});
        end
        if (cmd.i_step)
        begin
            i_next = i_inc;
        end
        if (cmd.j_step)
        begin
            j_next = j_dec;
        end
        if (cmd.swap_b || cmd.cross_step)
        begin
            i_next = i_inc;
            j_next = j_dec;
        end
        if (cmd.init_push)
        begin
            sp_next = sp_t'(1);
        end
        else if (stk_we)
        begin
            sp_next = sp_reg + sp_t'(1);
        end
        else if (cmd.pop)
        begin
            sp_next = sp_reg - sp_t'(1);
        end
        if (cmp_bump && cmp_reg != '1)
        begin
            cmp_next = cmp_reg + stat_t'(1);
        end
        // a meet counts its crossing test on top of the j-scan comparison
        if (cmd.cross_step && cmp_next != '1)
        begin
            cmp_next = cmp_next + stat_t'(1);
        end
        if (cmd.swap_a && swp_reg != '1)
        begin
            swp_next = swp_reg + stat_t'(1);
        end
        if (cmd.out_start)
        begin
            k_next = '0;
        end
        else if (cmd.out_next)
        begin
            k_next = k_reg + idx_t'(1);
        end
        if (cmd.run_clear)
        begin
            count_next   = '0;
            cmp_next     = '0;
            swp_next     = '0;
            dropped_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg       <= '0;
            j_reg       <= '0;
            count_reg   <= '0;
            sp_reg      <= '0;
            cmp_reg     <= '0;
            swp_reg     <= '0;
            dropped_reg <= 1'b0;
            k_reg       <= '0;
        end
        else
        begin
            i_reg       <= i_next;
            j_reg       <= j_next;
            count_reg   <= count_next;
            sp_reg      <= sp_next;
            cmp_reg     <= cmp_next;
            swp_reg     <= swp_next;
            dropped_reg <= dropped_next;
            k_reg       <= k_next;
        end
    end

    // status back to the controller
    assign stat.sp_empty   = (sp_reg == '0);
    assign stat.range_bad  = (stk_lo > stk_hi);
    assign stat.i_go       = (i_reg < hi_pos) && (store_rd_reg < x_reg);
    assign stat.j_go       = (j_reg > lo_pos) && (store_rd_reg > x_reg);
    assign stat.i_lt_j     = (i_reg < j_reg);
    assign stat.i_le_j     = (i_reg <= j_reg);
    assign stat.gap_two    = (gap > pos_t'(1));
    assign stat.hi_pending = (i_reg < hi_pos);
    assign stat.lo_pending = (lo_pos < j_reg);
    assign stat.last_out   = (k_reg == last_k[IDX_W-1:0]);

    // result fields
    assign sorted_value  = store_rd_reg;
    assign run_end       = stat.last_out;
    assign compare_count = cmp_reg;
    assign swap_count    = swp_reg;
    assign overflow_flag = dropped_reg;

    // stack pointer never passes the stack depth
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= sp_t'(STACK_DEPTH))
        else $error("range stack pointer out of bounds");

    // comparison counter only moves up within a run
    a_cmp_mono: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cmd.run_clear) |-> cmp_reg >= $past(cmp_reg))
        else $error("comparison counter went backwards");

    // scan index never runs past the store capacity (MAX_ELEMENTS)
    a_i_bound: assert property (@(posedge clk) disable iff (!rst_n)
        i_reg <= pos_t'(MAX_ELEMENTS))
        else $error("scan index past store");

endmodule

// ===== hw/rtl/qsort_ctrl.sv =====
// ----------------------------------------------------------------------------
// qsort_ctrl
// Controller: load phase, partition sequencing over the range stack and
// readout handshake. Issues one command word per cycle to the datapath.
// ----------------------------------------------------------------------------
module qsort_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   final_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  qsort_pkg::qsort_stat_t stat,
    output qsort_pkg::qsort_cmd_t  cmd
);
    import qsort_pkg::*;

    typedef enum logic [12:0] {
        S_LOAD     = 13'h0001,
        S_INIT     = 13'h0002,
        S_POP      = 13'h0004,
        S_RANGE    = 13'h0008,
        S_PIVOT    = 13'h0010,
        S_SCAN_I   = 13'h0020,
        S_SCAN_J   = 13'h0040,
        S_SWAP_A   = 13'h0080,
        S_SWAP_B   = 13'h0100,
        S_PUSH_HI  = 13'h0200,
        S_PUSH_LO  = 13'h0400,
        S_OUT_RD   = 13'h0800,
        S_OUT_WAIT = 13'h1000
    } state_t;

    state_t state_reg, state_next;
    logic   in_fire;
    logic   out_fire;

    assign in_ready  = (state_reg == S_LOAD);
    assign out_valid = (state_reg == S_OUT_WAIT);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;

    // next state and command word
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_K;
        case (state_reg)
            S_LOAD:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    if (final_item)
                    begin
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                cmd.init_push = 1'b1;
                state_next    = S_POP;
            end
            S_POP:
            begin
                if (stat.sp_empty)
                begin
                    cmd.out_start = 1'b1;
                    state_next    = S_OUT_RD;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_RANGE;
                end
            end
            S_RANGE:
            begin
                if (stat.range_bad)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    cmd.range_load = 1'b1;
                    cmd.rd_sel     = RD_MID;
                    state_next     = S_PIVOT;
                end
            end
            S_PIVOT:
            begin
                cmd.pivot_load = 1'b1;
                cmd.rd_sel     = RD_I;
                state_next     = S_SCAN_I;
            end
            S_SCAN_I:
            begin
                if (stat.i_go)
                begin
                    cmd.i_step = 1'b1;
                    cmd.rd_sel = RD_I_NEXT;
                end
                else
                begin
                    cmd.i_done = 1'b1;
                    cmd.rd_sel = RD_J;
                    state_next = S_SCAN_J;
                end
            end
            S_SCAN_J:
            begin
                if (stat.j_go)
                begin
                    cmd.j_step = 1'b1;
                    cmd.rd_sel = RD_J_PREV;
                end
                else
                begin
                    cmd.j_done = 1'b1;
                    if (stat.i_lt_j)
                    begin
                        state_next = S_SWAP_A;
                    end
                    else
                    begin
                        // indices meet or cross: step past each other only when equal, no exchange
                        cmd.cross_step = stat.i_le_j;
                        state_next     = S_PUSH_HI;
                    end
                end
            end
            S_SWAP_A:
            begin
                cmd.swap_a = 1'b1;
                state_next = S_SWAP_B;
            end
            S_SWAP_B:
            begin
                cmd.swap_b = 1'b1;
                if (stat.gap_two)
                begin
                    cmd.rd_sel = RD_I_NEXT;
                    state_next = S_SCAN_I;
                end
                else
                begin
                    state_next = S_PUSH_HI;
                end
            end
            S_PUSH_HI:
            begin
                cmd.push_hi = stat.hi_pending;
                state_next  = S_PUSH_LO;
            end
            S_PUSH_LO:
            begin
                cmd.push_lo = stat.lo_pending;
                state_next  = S_POP;
            end
            S_OUT_RD:
            begin
                state_next = S_OUT_WAIT;
            end
            S_OUT_WAIT:
            begin
                if (out_fire)
                begin
                    cmd.out_next = 1'b1;
                    if (stat.last_out)
                    begin
                        cmd.run_clear = 1'b1;
                        state_next    = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // loading and readout never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output phases overlap");

    // a final item closes the load phase
    a_final_stops_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && final_item) |=> !in_ready)
        else $error("still loading after final item");

endmodule

// ===== tb/tb_quicksort_engine_with_counters_top.sv =====
// ----------------------------------------------------------------------------
// tb_quicksort_engine_with_counters_top
// Self-checking bench for the quicksort engine: values are loaded run by run
// and each sorted item with its comparison and exchange counts is checked
// against a behavioral quicksort kept in step with every accepted item.
// ----------------------------------------------------------------------------
module tb_quicksort_engine_with_counters_top;

    import qsort_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 40;
    localparam int ITEM_TARGET  = 210;
    localparam int IDLE_PCT     = 34;
    localparam int MAX_REPORTS  = 40;
    localparam int COUNT_TOP    = (1 << COUNT_BITS) - 1;

    localparam value_t VALUE_MIN    = 16'sh8000;
    localparam value_t VALUE_MAX    = 16'sh7FFF;
    localparam stat_t  ONE_ELEM_CMP = 16'd3;

    // value mix of one random run
    typedef enum logic [2:0] {
        MIX_FULL,
        MIX_NARROW,
        MIX_SAME,
        MIX_RISING,
        MIX_FALLING
    } run_mix_t;

    typedef struct packed {
        value_t value;
        logic   last;
        stat_t  compares;
        stat_t  swaps;
        logic   dropped;
    } sorted_item_t;

    // one directed item; the expected result is typed only for one-value runs
    typedef struct packed {
        value_t value;
        logic   last;
        logic   typed;
        value_t want_value;
        stat_t  want_cmp;
        stat_t  want_swp;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 23;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // one-value runs at the extremes, zero and minus one
        '{VALUE_MIN,  1'b1, 1'b1, VALUE_MIN, ONE_ELEM_CMP, 16'd0},
        '{VALUE_MAX,  1'b1, 1'b1, VALUE_MAX, ONE_ELEM_CMP, 16'd0},
        '{16'sd0,     1'b1, 1'b1, 16'sd0,    ONE_ELEM_CMP, 16'd0},
        '{-16'sd1,    1'b1, 1'b1, -16'sd1,   ONE_ELEM_CMP, 16'd0},
        // two values, reversed extremes
        '{VALUE_MAX,  1'b0, 1'b0, 16'sd0, 16'd0, 16'd0},
        '{VALUE_MIN,  1'b1, 1'b0, 16'sd0, 16'd0, 16'd0},
        // all equal
        '{16'sd5,     1'b0, 1'b0, 16'sd0, 16'd0, 16'd0},
        '{16'sd5,     1'b0, 1'b0, 16'sd0, 16'd0, 16'd0},
        '{16'sd5,     1'b1, 1'b0, 16'sd0, 16'd0, 16'd0},
        // descending across zero
        '{16'sd100,   1'b0, 1'b0, 16'sd0, 16'd0, 16'd0},
        '{16'sd50,    1'b0, 1'b0, 16'sd0, 16'd0, 16'd0},
        '{16'sd0,     1'b0, 1'b0, 16'sd0, 16'd0, 16'd0},
        '{-16'sd50,   1'b0, 1'b0, 16'sd0, 16'd0, 16'd0},
        '{-16'sd100,  1'b1, 1'b0, 16'sd0, 16'd0, 16'd0},
        // already ascending
        '{VALUE_MIN,  1'b0, 1'b0, 16'sd0, 16'd0, 16'd0},
        '{-16'sd1,    1'b0, 1'b0, 16'sd0, 16'd0, 16'd0},
        '{16'sd0,     1'b0, 1'b0, 16'sd0, 16'd0, 16'd0},
        '{16'sd1,     1'b0, 1'b0, 16'sd0, 16'd0, 16'd0},
        '{VALUE_MAX,  1'b1, 1'b0, 16'sd0, 16'd0, 16'd0},
        // alternating bit patterns with duplicates
        '{16'sh5555,  1'b0, 1'b0, 16'sd0, 16'd0, 16'd0},
        '{16'shAAAA,  1'b0, 1'b0, 16'sd0, 16'd0, 16'd0},
        '{16'sh5555,  1'b0, 1'b0, 16'sd0, 16'd0, 16'd0},
        '{16'shAAAA,  1'b1, 1'b0, 16'sd0, 16'd0, 16'd0}
    };

    logic               clk;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_ready;
    logic signed [15:0] load_value   = '0;
    logic               final_item   = 1'b0;
    logic               out_valid;
    logic               out_ready    = 1'b0;
    logic signed [15:0] sorted_value;
    logic               run_end;
    logic [15:0]        compare_count;
    logic [15:0]        swap_count;
    logic               overflow_flag;

    // behavioral copy of the store and run counters
    value_t sort_store [MAX_ELEMENTS];
    int     stored_count = 0;
    int     cmp_tally    = 0;
    int     xchg_tally   = 0;
    bit     drop_seen    = 1'b0;

    sorted_item_t sorted_pending [$];

    int err_count       = 0;
    int results_checked = 0;
    int items_sent      = 0;
    int runs_done       = 0;
    int overflow_runs   = 0;
    int longest_run     = 0;
    int cycle_count     = 0;
    int hold_left       = 0;
    bit hold_done       = 1'b0;
    bit calm            = 1'b0;

    quicksort_engine_with_counters_top uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .load_value    (load_value),
        .final_item    (final_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sorted_value  (sorted_value),
        .run_end       (run_end),
        .compare_count (compare_count),
        .swap_count    (swap_count),
        .overflow_flag (overflow_flag)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_fault(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("ERROR @%0d: %s", cycle_count, msg);
    endtask

    function automatic void tally_up(inout int c);
        if (c < COUNT_TOP)
            c++;
    endfunction

    // hoare partition with middle pivot, pending ranges on an explicit stack
    function automatic void quicksort_store(input int n);
        int     lo_stack [$];
        int     hi_stack [$];
        int     lo;
        int     hi;
        int     i;
        int     j;
        value_t pivot;
        value_t t;
        if (n < 1)
            return;
        lo_stack.push_back(0);
        hi_stack.push_back(n - 1);
        while (lo_stack.size() > 0)
        begin
            lo = lo_stack.pop_back();
            hi = hi_stack.pop_back();
            if (lo > hi)
                continue;
            i = lo;
            j = hi;
            pivot = sort_store[(lo + hi) / 2];
            do
            begin
                while (i < hi && sort_store[i] < pivot)
                    i++;
                tally_up(cmp_tally);
                while (j > lo && sort_store[j] > pivot)
                    j--;
                tally_up(cmp_tally);
                if (i <= j)
                begin
                    if (i < j)
                    begin
                        t = sort_store[i];
                        sort_store[i] = sort_store[j];
                        sort_store[j] = t;
                        tally_up(xchg_tally);
                    end
                    i++;
                    j--;
                    tally_up(cmp_tally);
                end
            end
            while (i <= j);
            if (i < hi && lo_stack.size() < STACK_DEPTH)
            begin
                lo_stack.push_back(i);
                hi_stack.push_back(hi);
            end
            if (lo < j && lo_stack.size() < STACK_DEPTH)
            begin
                lo_stack.push_back(lo);
                hi_stack.push_back(j);
            end
        end
    endfunction

    // append one accepted value; on the last one sort and, if asked, queue the readout
    function automatic void absorb_value(input value_t v, input logic fin,
                                         input bit queue_results);
        sorted_item_t r;
        if (stored_count < MAX_ELEMENTS)
        begin
            sort_store[stored_count] = v;
            stored_count++;
        end
        else
            drop_seen = 1'b1;
        if (!fin)
            return;
        quicksort_store(stored_count);
        if (queue_results)
            for (int k = 0; k < stored_count; k++)
            begin
                r.value    = sort_store[k];
                r.last     = (k == stored_count - 1);
                r.compares = stat_t'(cmp_tally);
                r.swaps    = stat_t'(xchg_tally);
                r.dropped  = drop_seen;
                sorted_pending.push_back(r);
            end
        runs_done++;
        if (drop_seen)
            overflow_runs++;
        if (stored_count > longest_run)
            longest_run = stored_count;
        stored_count = 0;
        cmp_tally    = 0;
        xchg_tally   = 0;
        drop_seen    = 1'b0;
    endfunction

    // offer one item, returning at the edge where it is taken
    task automatic offer_value(input value_t v, input logic fin);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        load_value <= v;
        final_item <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // compare one accepted result with the oldest expectation
    task automatic check_sorted_item();
        sorted_item_t want;
        if (sorted_pending.size() == 0)
        begin
            report_fault($sformatf("unexpected item, sorted_value %0d", sorted_value));
            return;
        end
        want = sorted_pending.pop_front();
        results_checked++;
        if (sorted_value !== want.value)
            report_fault($sformatf("sorted_value: expected %0d, got %0d",
                                   want.value, sorted_value));
        if (run_end !== want.last)
            report_fault($sformatf("run_end: expected %0b, got %0b", want.last, run_end));
        if (compare_count !== want.compares)
            report_fault($sformatf("compare_count: expected %0d, got %0d",
                                   want.compares, compare_count));
        if (swap_count !== want.swaps)
            report_fault($sformatf("swap_count: expected %0d, got %0d",
                                   want.swaps, swap_count));
        if (overflow_flag !== want.dropped)
            report_fault($sformatf("overflow_flag: expected %0b, got %0b",
                                   want.dropped, overflow_flag));
    endtask

    // receiver: check taken items, random stalls, one long hold-off
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_sorted_item();
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (!hold_done && results_checked >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
            out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d items still expected",
                     cycle_count, sorted_pending.size());
            $display("quicksort_engine_with_counters_top regression: fail");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int       run_idx;
        int       run_len;
        int       step;
        value_t   base;
        value_t   v;
        run_mix_t run_mix;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            offer_value(directed_rows[r].value, directed_rows[r].last);
            absorb_value(directed_rows[r].value, directed_rows[r].last,
                         !directed_rows[r].typed);
            if (directed_rows[r].typed)
                sorted_pending.push_back(sorted_item_t'{directed_rows[r].want_value, 1'b1,
                                                        directed_rows[r].want_cmp,
                                                        directed_rows[r].want_swp, 1'b0});
        end

        // random runs; one fills the store exactly, one overflows it
        run_idx = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (run_idx)
                2:       run_len = MAX_ELEMENTS;
                5:       run_len = MAX_ELEMENTS + 2;
                default: run_len = $urandom_range(1, 12);
            endcase
            calm    = (run_idx == 3 || run_idx == 4);
            run_mix = run_mix_t'($urandom_range(0, 4));
            base    = value_t'($urandom);
            step    = $urandom_range(1, 700);
            for (int k = 0; k < run_len; k++)
            begin
                case (run_mix)
                    MIX_NARROW:  v = value_t'($urandom_range(0, 6)) - 16'sd3;
                    MIX_SAME:    v = base;
                    MIX_RISING:  v = base + value_t'(k * step);
                    MIX_FALLING: v = base - value_t'(k * step);
                    default:     v = value_t'($urandom);
                endcase
                offer_value(v, k == run_len - 1);
                absorb_value(v, k == run_len - 1, 1'b1);
            end
            run_idx++;
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // drain
        while (sorted_pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d items in %0d sorts (%0d with dropped values, longest %0d)",
                 items_sent, runs_done, overflow_runs, longest_run);
        $display("%0d sorted items checked, receiver held off %0d cycles, %0d mismatches",
                 results_checked, HOLD_CYCLES, err_count);
        if (err_count == 0)
            $display("quicksort_engine_with_counters_top regression: pass");
        else
            $display("quicksort_engine_with_counters_top regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/qsort_pkg.sv
hw/rtl/qsort_dp.sv
hw/rtl/qsort_ctrl.sv
hw/rtl/quicksort_engine_with_counters_top.sv
tb/tb_quicksort_engine_with_counters_top.sv
